// ===== rtl/core/smls_pkg.sv =====
// shared types, codes and widths of the sparse matrix list store
package smls_pkg;

    // default sizing of the store
    localparam int DIM_MAX_DEF       = 1024;
    localparam int LIST_CAPACITY_DEF = 16;

    // field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int STAT_W  = 2;
    localparam int NZ_W    = 15;
    localparam int CNT_W   = 11;
    localparam int CFG_IW  = 2;
    localparam int IN_W    = 88;
    localparam int OUT_W   = 88;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ORIENT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COLS   = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEN,
        S_SCAN,
        S_FINISH
    } t_state;

    // request handed to the engine
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] list;
        logic [IDX_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             range_err;
    } t_req;

    // result returned by the engine
    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic              found;
        logic [STAT_W-1:0] status;
        logic [NZ_W-1:0]   nonzero_count;
    } t_res;

endpackage

// ===== rtl/core/smls_engine.sv =====
// list store engine: length and entry memories with the search sequencer
module smls_engine #(
    parameter int DIM_MAX       = smls_pkg::DIM_MAX_DEF,
    parameter int LIST_CAPACITY = smls_pkg::LIST_CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  smls_pkg::t_req  i_req,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output smls_pkg::t_res  o_res
);

    localparam int LW    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int KW    = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int LENW  = $clog2(LIST_CAPACITY + 1);
    localparam int DEPTH = DIM_MAX * LIST_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = smls_pkg::IDX_W + smls_pkg::VAL_W;

    // memories
    logic [LENW-1:0] r_len_mem [DIM_MAX];
    logic [EW-1:0]   r_ent_mem [DEPTH];
    logic [LENW-1:0] r_len_q;
    logic [EW-1:0]   r_ent_q;

    // sequencer registers
    smls_pkg::t_state            r_state, n_state;
    smls_pkg::t_req              r_req;
    logic [LW-1:0]               r_clr_addr, n_clr_addr;
    logic [KW-1:0]               r_k, n_k;
    logic                        r_match, n_match;
    logic [KW-1:0]               r_hit, n_hit;
    logic [smls_pkg::VAL_W-1:0]  r_hit_value, n_hit_value;
    logic [smls_pkg::NZ_W-1:0]   r_total, n_total;

    // memory control
    logic            w_len_we, w_len_re;
    logic [LW-1:0]   w_len_addr;
    logic [LENW-1:0] w_len_wdata;
    logic            w_ent_we, w_ent_re;
    logic [KW-1:0]   w_ent_k;
    logic [AW-1:0]   w_ent_addr;
    logic [EW-1:0]   w_ent_wdata;

    logic            w_accept;
    logic [LW-1:0]   w_list;
    logic [LENW-1:0] w_k_next;
    logic            w_full;
    logic            w_is_write;

    assign w_accept    = i_req_valid && o_req_ready;
    assign w_list      = LW'(r_req.list);
    assign w_k_next    = LENW'(r_k) + LENW'(1);
    assign w_full      = (r_len_q >= LENW'(LIST_CAPACITY));
    assign w_is_write  = (r_req.cmd == smls_pkg::CMD_SET) ||
                         (r_req.cmd == smls_pkg::CMD_APPEND);
    assign w_ent_addr  = AW'(w_list) * AW'(LIST_CAPACITY) + AW'(w_ent_k);
    assign w_ent_wdata = {r_req.key, r_req.value};

    // length memory
    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_len_mem[w_len_addr] <= w_len_wdata;
        end
        if (w_len_re) begin
            r_len_q <= r_len_mem[w_len_addr];
        end
    end

    // entry memory, key and value side by side
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_ent_mem[w_ent_addr] <= w_ent_wdata;
        end
        if (w_ent_re) begin
            r_ent_q <= r_ent_mem[w_ent_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= smls_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_total    <= n_total;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_k         <= n_k;
        r_match     <= n_match;
        r_hit       <= n_hit;
        r_hit_value <= n_hit_value;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_k         = r_k;
        n_match     = r_match;
        n_hit       = r_hit;
        n_hit_value = r_hit_value;
        n_total     = r_total;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.nonzero_count = r_total;
        w_len_we    = 1'b0;
        w_len_re    = 1'b0;
        w_len_addr  = w_list;
        w_len_wdata = r_len_q + LENW'(1);
        w_ent_we    = 1'b0;
        w_ent_re    = 1'b0;
        w_ent_k     = r_k;
        unique case (r_state)
            smls_pkg::S_CLEAR: begin
                w_len_we    = 1'b1;
                w_len_addr  = r_clr_addr;
                w_len_wdata = '0;
                n_clr_addr  = r_clr_addr + LW'(1);
                if (r_clr_addr == LW'(DIM_MAX - 1)) begin
                    n_state = smls_pkg::S_IDLE;
                end
            end
            smls_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                w_len_addr  = LW'(i_req.list);
                if (i_req_valid) begin
                    w_len_re = 1'b1;
                    n_match  = 1'b0;
                    n_state  = smls_pkg::S_LEN;
                end
            end
            smls_pkg::S_LEN: begin
                // no search for append, empty lists or bad indexes
                if (r_req.range_err || (r_req.cmd == smls_pkg::CMD_APPEND) ||
                    (r_len_q == '0)) begin
                    n_state = smls_pkg::S_FINISH;
                end else begin
                    w_ent_k  = '0;
                    w_ent_re = 1'b1;
                    n_k      = '0;
                    n_state  = smls_pkg::S_SCAN;
                end
            end
            smls_pkg::S_SCAN: begin
                // compare the entry read last cycle, fetch the next one
                if (r_ent_q[EW-1:smls_pkg::VAL_W] == r_req.key) begin
                    n_match     = 1'b1;
                    n_hit       = r_k;
                    n_hit_value = r_ent_q[smls_pkg::VAL_W-1:0];
                    n_state     = smls_pkg::S_FINISH;
                end else if (w_k_next >= r_len_q) begin
                    n_state = smls_pkg::S_FINISH;
                end else begin
                    w_ent_k  = KW'(w_k_next);
                    w_ent_re = 1'b1;
                    n_k      = KW'(w_k_next);
                end
            end
            smls_pkg::S_FINISH: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = smls_pkg::S_IDLE;
                    if (r_req.range_err) begin
                        o_res.status = smls_pkg::STAT_RANGE;
                    end else if (w_is_write) begin
                        if ((r_req.cmd == smls_pkg::CMD_SET) && r_match) begin
                            // overwrite the matching entry
                            w_ent_k     = r_hit;
                            w_ent_we    = 1'b1;
                            o_res.found = 1'b1;
                        end else if (w_full) begin
                            o_res.status = smls_pkg::STAT_FULL;
                        end else begin
                            // append at the list tail
                            w_ent_k  = KW'(r_len_q);
                            w_ent_we = 1'b1;
                            w_len_we = 1'b1;
                            n_total  = r_total + smls_pkg::NZ_W'(1);
                        end
                    end else begin
                        o_res.found      = r_match;
                        o_res.read_value = r_match ? r_hit_value : '0;
                    end
                    o_res.nonzero_count = n_total;
                end
            end
            default: begin
                n_state = smls_pkg::S_IDLE;
            end
        endcase
    end

    // a list never grows beyond its capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_len_we && (r_state != smls_pkg::S_CLEAR)) |->
            (w_len_wdata <= LENW'(LIST_CAPACITY)))
        else $error("list length written above capacity");

    // an accepted request always goes on to read its list length
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == smls_pkg::S_LEN))
        else $error("accepted request did not start the length read");

    // the search never walks past the list tail
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smls_pkg::S_SCAN) |-> (LENW'(r_k) < r_len_q))
        else $error("search index beyond list length");

    // bad indexes report nothing found and change no memory
    a_range_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_req.range_err) |->
            (!o_res.found && (o_res.read_value == '0) && !w_ent_we && !w_len_we &&
             (o_res.status == smls_pkg::STAT_RANGE)))
        else $error("out of range request produced data or a write");

endmodule

// ===== rtl/core/sparse_matrix_list_store.sv =====
// top level of the sparse matrix list store: ports, configuration, result register
//
// Keeps a sparse matrix as one bounded list per row (orientation 0) or per column
// (orientation 1), each list up to LIST_CAPACITY entries of {other index, 64-bit value}.
// Commands are get, set and append; every request gives one result carrying the value
// (get), a found flag, a status (ok, list full, index out of range) and the total entry
// count. One request is in work at a time. A request goes from accept through a length
// read, a search of up to the list's entries (none for append, empty lists and bad
// indexes) that walks the entry memory one entry a cycle, and a finish step back to idle.
// After reset a clearing pass zeroes all DIM_MAX entries of the list length memory,
// during which no request is taken; configuration writes are taken at any time. The
// result sits in an output register, so the next request is taken while a result waits.
module sparse_matrix_list_store #(
    parameter int DIM_MAX       = smls_pkg::DIM_MAX_DEF,
    parameter int LIST_CAPACITY = smls_pkg::LIST_CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // command[1:0], row_index[11:2], col_index[21:12], write_value[85:22], zero pad
    input  logic [smls_pkg::IN_W-1:0]   i_s_tdata,
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // read_value[63:0], found[64], status[66:65], nonzero_count[81:67], zero pad
    output logic [smls_pkg::OUT_W-1:0]  o_m_tdata,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [smls_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [smls_pkg::CNT_W-1:0]  i_cfg_data
);

    logic                        r_orientation;
    logic [smls_pkg::CNT_W-1:0]  r_row_count;
    logic [smls_pkg::CNT_W-1:0]  r_col_count;
    logic                        r_out_valid;
    smls_pkg::t_res              r_out;

    logic [smls_pkg::CMD_W-1:0]  w_cmd;
    logic [smls_pkg::IDX_W-1:0]  w_row;
    logic [smls_pkg::IDX_W-1:0]  w_col;
    logic [smls_pkg::VAL_W-1:0]  w_value;
    logic                        w_range_err;
    smls_pkg::t_req              w_req;
    smls_pkg::t_res              w_res;
    logic                        w_res_valid;
    logic                        w_res_ready;

    // request fields
    assign w_cmd   = i_s_tdata[1:0];
    assign w_row   = i_s_tdata[11:2];
    assign w_col   = i_s_tdata[21:12];
    assign w_value = i_s_tdata[85:22];

    // index range check against configured and built-in sizes
    assign w_range_err = ({1'b0, w_row} >= r_row_count) ||
                         ({1'b0, w_col} >= r_col_count) ||
                         (32'(w_row) >= 32'(DIM_MAX)) ||
                         (32'(w_col) >= 32'(DIM_MAX));

    // pick list and key by orientation
    always_comb begin
        w_req.cmd       = w_cmd;
        w_req.list      = r_orientation ? w_col : w_row;
        w_req.key       = r_orientation ? w_row : w_col;
        w_req.value     = w_value;
        w_req.range_err = w_range_err;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation <= 1'b0;
            r_row_count   <= smls_pkg::CNT_W'(1024);
            r_col_count   <= smls_pkg::CNT_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smls_pkg::CFG_ORIENT: r_orientation <= i_cfg_data[0];
                smls_pkg::CFG_ROWS:   r_row_count   <= i_cfg_data;
                smls_pkg::CFG_COLS:   r_col_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    smls_engine #(
        .DIM_MAX       (DIM_MAX),
        .LIST_CAPACITY (LIST_CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    // result packing
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.nonzero_count, r_out.status, r_out.found,
                         r_out.read_value};

endmodule
